>>> src/kpsd_pkg.sv
package kpsd_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_PRESS_SETTLE   = 1'b0;
  localparam cfg_index_t CFG_RELEASE_SETTLE = 1'b1;

  localparam int SETTLE_W = 6;
  typedef logic [SETTLE_W-1:0] settle_t;
  localparam settle_t PRESS_SETTLE_RST   = 6'd10;
  localparam settle_t RELEASE_SETTLE_RST = 6'd35;
  localparam settle_t SETTLE_MAX         = 6'd63;

  typedef logic [2:0] sense_t;
  typedef logic [2:0] row_cnt_t;
  typedef logic [7:0] key_t;
  typedef logic [1:0] row_sel_t;

  // Encoder codes: bit 1 = any key down, bits 2 and 0 = column
  localparam int     SENSE_ANY_BIT = 1;
  localparam sense_t SENSE_NONE    = 3'b000;
  localparam sense_t SENSE_COL0    = 3'b010;
  localparam sense_t SENSE_COL1    = 3'b110;
  localparam sense_t SENSE_COL2    = 3'b011;
  localparam sense_t SENSE_COL3    = 3'b111;

  localparam row_cnt_t ROW_FIRST = 3'd1;
  localparam row_cnt_t ROW_LAST  = 3'd4;
  localparam row_cnt_t ROW_WRAP  = 3'd5;

  localparam key_t KEY_NONE = 8'h00;
  localparam key_t KEY_MAP [4][4] = '{
    '{"1", "2", "3", "F"},
    '{"4", "5", "6", "E"},
    '{"7", "8", "9", "D"},
    '{"A", "0", "B", "C"}
  };

  // Step result handed from the scan FSM to the output register
  typedef struct packed {
    logic     key_found;
    key_t     key_code;
    row_sel_t row_select;
  } result_t;

  function automatic key_t key_lookup(input row_cnt_t row, input sense_t code);
    logic [1:0] r;
    key_t       k;
    r = 2'(row - 3'd1);
    unique case (code)
      SENSE_COL0: k = KEY_MAP[r][0];
      SENSE_COL1: k = KEY_MAP[r][1];
      SENSE_COL2: k = KEY_MAP[r][2];
      SENSE_COL3: k = KEY_MAP[r][3];
      default:    k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

>>> src/kpsd_if.sv
interface kpsd_in_if;
  logic                   valid;
  logic                   ready;
  logic                   func;
  kpsd_pkg::sense_t       sense_code;

  modport source (output valid, func, sense_code, input ready);
  modport sink   (input valid, func, sense_code, output ready);
endinterface

interface kpsd_out_if;
  logic                   valid;
  logic                   ready;
  logic                   key_found;
  kpsd_pkg::key_t         key_code;
  kpsd_pkg::row_sel_t     row_select;

  modport source (output valid, key_found, key_code, row_select, input ready);
  modport sink   (input valid, key_found, key_code, row_select, output ready);
endinterface

>>> src/kpsd_fsm.sv
module kpsd_fsm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  kpsd_pkg::cfg_index_t  cfg_index,
  input  kpsd_pkg::settle_t     cfg_wdata,
  input  logic                  step,
  input  logic                  func,
  input  kpsd_pkg::sense_t      sense_code,
  output kpsd_pkg::result_t     res
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CAPTURE, ST_DEBOUNCE, ST_GETKEY, ST_WAITREL, ST_RELDEB, ST_RELEASED
  } state_t;

  state_t              state_r, state_nxt;
  kpsd_pkg::row_cnt_t  row_cnt_r, row_cnt_nxt;
  kpsd_pkg::sense_t    capt_r, capt_nxt;
  logic                found_r, found_nxt;
  kpsd_pkg::key_t      last_key_r, last_key_nxt;
  kpsd_pkg::row_sel_t  row_lines_r, row_lines_nxt;
  kpsd_pkg::settle_t   settle_r, settle_nxt;
  kpsd_pkg::settle_t   press_ticks_r, release_ticks_r;
  kpsd_pkg::row_cnt_t  row_inc;

  assign row_inc = row_cnt_r + 3'd1;

  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    capt_nxt      = capt_r;
    found_nxt     = found_r;
    last_key_nxt  = last_key_r;
    row_lines_nxt = row_lines_r;
    settle_nxt    = settle_r;
    if (step) begin
      if (func) begin
        if (settle_r < kpsd_pkg::SETTLE_MAX) begin
          settle_nxt = settle_r + 6'd1;
        end
      end else begin
        unique case (state_r)
          ST_IDLE: begin
            found_nxt = 1'b0;
            if (row_cnt_r == kpsd_pkg::ROW_WRAP) begin
              // wrap to row one, then step on to row two unless a key is down
              row_lines_nxt = '0;
              if (sense_code[kpsd_pkg::SENSE_ANY_BIT]) begin
                row_cnt_nxt = kpsd_pkg::ROW_FIRST;
                state_nxt   = ST_CAPTURE;
              end else begin
                row_cnt_nxt   = kpsd_pkg::ROW_FIRST + 3'd1;
                row_lines_nxt = 2'd1;
              end
            end else if (sense_code[kpsd_pkg::SENSE_ANY_BIT]) begin
              state_nxt = ST_CAPTURE;
            end else begin
              row_cnt_nxt = row_inc;
              if (row_inc >= kpsd_pkg::ROW_FIRST && row_inc <= kpsd_pkg::ROW_LAST) begin
                row_lines_nxt = 2'(row_inc - 3'd1);
              end
            end
          end
          ST_CAPTURE: begin
            capt_nxt   = sense_code;
            state_nxt  = ST_DEBOUNCE;
            settle_nxt = '0;
          end
          ST_DEBOUNCE: begin
            if (settle_r >= press_ticks_r) begin
              if (sense_code == capt_r) begin
                state_nxt = ST_GETKEY;
              end
              settle_nxt = '0;
            end
          end
          ST_GETKEY: begin
            last_key_nxt = kpsd_pkg::key_lookup(row_cnt_r, capt_r);
            found_nxt    = 1'b1;
            state_nxt    = ST_WAITREL;
          end
          ST_WAITREL: begin
            found_nxt = 1'b0;
            if (sense_code[kpsd_pkg::SENSE_ANY_BIT]) begin
              state_nxt  = ST_RELDEB;
              settle_nxt = '0;
            end else begin
              state_nxt = ST_RELEASED;
            end
          end
          ST_RELDEB: begin
            if (settle_r >= release_ticks_r) begin
              if (sense_code == kpsd_pkg::SENSE_NONE) begin
                state_nxt = ST_RELEASED;
              end
              settle_nxt = '0;
            end
          end
          ST_RELEASED: begin
            state_nxt   = ST_IDLE;
            row_cnt_nxt = kpsd_pkg::ROW_FIRST;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
    end
  end

  assign res.key_found  = ~func & found_nxt;
  assign res.key_code   = last_key_nxt;
  assign res.row_select = row_lines_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      row_cnt_r       <= kpsd_pkg::ROW_FIRST;
      capt_r          <= kpsd_pkg::SENSE_NONE;
      found_r         <= 1'b0;
      last_key_r      <= kpsd_pkg::KEY_NONE;
      row_lines_r     <= '0;
      settle_r        <= '0;
      press_ticks_r   <= kpsd_pkg::PRESS_SETTLE_RST;
      release_ticks_r <= kpsd_pkg::RELEASE_SETTLE_RST;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      capt_r      <= capt_nxt;
      found_r     <= found_nxt;
      last_key_r  <= last_key_nxt;
      row_lines_r <= row_lines_nxt;
      settle_r    <= settle_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          kpsd_pkg::CFG_PRESS_SETTLE:   press_ticks_r   <= cfg_wdata;
          kpsd_pkg::CFG_RELEASE_SETTLE: release_ticks_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_tick_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    step && func |=> $stable(state_r))
    else $error("tick moved the scan state");

  a_found_only_getkey: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.key_found |-> state_r == ST_GETKEY)
    else $error("key_found outside key lookup");

  a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    step && func && settle_r != kpsd_pkg::SETTLE_MAX |=> settle_r == $past(settle_r) + 6'd1)
    else $error("settle counter missed a tick");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_cnt_r >= kpsd_pkg::ROW_FIRST && row_cnt_r <= kpsd_pkg::ROW_WRAP)
    else $error("row counter out of range");
`endif

endmodule

>>> src/keypad_scan_debounce.sv
// 4x4 keypad scanner with press and release debounce.
// in_ch  : one transfer per item. func=0 is a scan poll carrying the column
//          encoder code in sense_code; func=1 is a one millisecond tick.
// out_ch : exactly one result transfer per input item, in order:
//          key_found (pulse on the poll that decodes a key), key_code (ASCII
//          of the last decoded key, 0 for none or an unknown column code) and
//          row_select (row decoder drive, 0..3).
// cfg    : cfg_we/cfg_index/cfg_wdata write press (index 0) and release
//          (index 1) settle times in ticks; write only while idle.
// Timing: the result enters the output register in the cycle after the input
//          transfer. Throughput: one item per cycle while out_ch takes results,
//          set by the single registered state update of the scan FSM.
// Reset (synchronous, rst_n low): FSM idle, row counter at row one, key code
//          0, settle times 10 and 35 ticks, output register empty.
// Stall: while out_ch is held, one more item is taken into the output
//          register only if it is empty; in_ch.ready drops when the output
//          register is full and not being taken.
module keypad_scan_debounce (
  input  logic                  clk,
  input  logic                  rst_n,
  kpsd_in_if.sink               in_ch,
  kpsd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  kpsd_pkg::cfg_index_t  cfg_index,
  input  kpsd_pkg::settle_t     cfg_wdata
);

  logic              in_xfer;
  logic              out_valid_r;
  kpsd_pkg::result_t res;
  kpsd_pkg::result_t res_r;

  // Output register frees up in the same cycle it is drained
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign in_xfer     = in_ch.valid & in_ch.ready;

  kpsd_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .step       (in_xfer),
    .func       (in_ch.func),
    .sense_code (in_ch.sense_code),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.key_found  = res_r.key_found;
  assign out_ch.key_code   = res_r.key_code;
  assign out_ch.row_select = res_r.row_select;

`ifndef NO_ASSERTIONS
  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted item left no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_xfer)
    else $error("pending result overwritten");
`endif

endmodule

>>> tb/keypad_scan_debounce_tb.sv
module keypad_scan_debounce_tb;

  // Run limits. The cycle limit is roomy even for the slowest legal run (every
  // transfer meeting a long source gap and a long sink stall).
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 250;   // forced sink hold-off, in cycles
  localparam int MAX_REPORTS = 10;

  // Item kinds on the input channel
  localparam logic FUNC_POLL = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Encoder codes with the any-key bit clear (no key down)
  localparam kpsd_pkg::sense_t SENSE_STRAY_B0  = 3'b001;
  localparam kpsd_pkg::sense_t SENSE_STRAY_B2  = 3'b100;
  localparam kpsd_pkg::sense_t SENSE_STRAY_B20 = 3'b101;

  typedef struct packed {
    logic             is_tick;
    kpsd_pkg::sense_t code;
  } keypad_event_t;

  // Scanner phases, in the block's own order
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_CAPTURE, SCAN_PRESS_WAIT, SCAN_DECODE,
    SCAN_HOLD, SCAN_RELEASE_WAIT, SCAN_DONE
  } scan_phase_t;

  logic clk;
  logic rst_n;

  kpsd_in_if  in_ch();
  kpsd_out_if out_ch();

  logic                 cfg_we;
  kpsd_pkg::cfg_index_t cfg_index;
  kpsd_pkg::settle_t    cfg_wdata;

  // Channel drive, held in local regs so every input is known from time 0
  logic             drv_valid = 1'b0;
  logic             drv_func  = FUNC_POLL;
  kpsd_pkg::sense_t drv_code  = kpsd_pkg::SENSE_NONE;
  logic             sink_ready = 1'b0;

  assign in_ch.valid      = drv_valid;
  assign in_ch.func       = drv_func;
  assign in_ch.sense_code = drv_code;
  assign out_ch.ready     = sink_ready;

  keypad_scan_debounce dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Scanner prediction: own copy of the state and the settle settings
  // ---------------------------------------------------------------------
  scan_phase_t          phase;
  kpsd_pkg::row_cnt_t   row_ptr;
  kpsd_pkg::sense_t     latched_code;
  logic                 key_pulse;
  kpsd_pkg::key_t       held_key;
  kpsd_pkg::row_sel_t   row_drive;
  kpsd_pkg::settle_t    tick_count;
  kpsd_pkg::settle_t    press_wait;
  kpsd_pkg::settle_t    release_wait;

  task automatic reset_scanner();
    press_wait   = kpsd_pkg::PRESS_SETTLE_RST;
    release_wait = kpsd_pkg::RELEASE_SETTLE_RST;
    phase        = SCAN_IDLE;
    row_ptr      = kpsd_pkg::ROW_FIRST;
    latched_code = kpsd_pkg::SENSE_NONE;
    key_pulse    = 1'b0;
    held_key     = kpsd_pkg::KEY_NONE;
    row_drive    = '0;
    tick_count   = '0;
  endtask

  // Row numbers outside 1..4 leave the decoder drive alone
  function automatic void select_row(input kpsd_pkg::row_cnt_t n);
    if (n >= kpsd_pkg::ROW_FIRST && n <= kpsd_pkg::ROW_LAST)
      row_drive = kpsd_pkg::row_sel_t'(n - kpsd_pkg::ROW_FIRST);
  endfunction

  function automatic kpsd_pkg::key_t decode_key(input kpsd_pkg::row_cnt_t row,
                                                input kpsd_pkg::sense_t code);
    kpsd_pkg::row_sel_t r;
    int                 col;
    r   = kpsd_pkg::row_sel_t'(row - kpsd_pkg::ROW_FIRST);
    col = -1;
    case (code)
      kpsd_pkg::SENSE_COL0: col = 0;
      kpsd_pkg::SENSE_COL1: col = 1;
      kpsd_pkg::SENSE_COL2: col = 2;
      kpsd_pkg::SENSE_COL3: col = 3;
      default:              col = -1;
    endcase
    return (col < 0) ? kpsd_pkg::KEY_NONE : kpsd_pkg::KEY_MAP[r][col];
  endfunction

  function automatic kpsd_pkg::result_t advance_scanner(input logic is_tick,
                                                        input kpsd_pkg::sense_t code);
    kpsd_pkg::result_t r;
    logic              pressed;
    pressed     = code[kpsd_pkg::SENSE_ANY_BIT];
    r.key_found = 1'b0;
    if (is_tick) begin
      // ticks only feed the settle counter, which sticks at its top
      if (tick_count != kpsd_pkg::SETTLE_MAX)
        tick_count = tick_count + 1'b1;
    end else begin
      case (phase)
        SCAN_IDLE: begin
          key_pulse = 1'b0;
          if (row_ptr == kpsd_pkg::ROW_WRAP) begin
            row_ptr = kpsd_pkg::ROW_FIRST;
            select_row(row_ptr);
          end
          if (pressed) begin
            phase = SCAN_CAPTURE;
          end else begin
            row_ptr = row_ptr + 1'b1;
            select_row(row_ptr);
          end
        end
        SCAN_CAPTURE: begin
          latched_code = code;
          phase        = SCAN_PRESS_WAIT;
          tick_count   = '0;
        end
        SCAN_PRESS_WAIT: begin
          // poll is held until enough ticks; a bounce restarts the wait
          if (tick_count >= press_wait) begin
            if (code == latched_code)
              phase = SCAN_DECODE;
            tick_count = '0;
          end
        end
        SCAN_DECODE: begin
          held_key  = decode_key(row_ptr, latched_code);
          key_pulse = 1'b1;
          phase     = SCAN_HOLD;
        end
        SCAN_HOLD: begin
          key_pulse = 1'b0;
          if (pressed) begin
            phase      = SCAN_RELEASE_WAIT;
            tick_count = '0;
          end else begin
            phase = SCAN_DONE;
          end
        end
        SCAN_RELEASE_WAIT: begin
          if (tick_count >= release_wait) begin
            if (code == kpsd_pkg::SENSE_NONE)
              phase = SCAN_DONE;
            tick_count = '0;
          end
        end
        SCAN_DONE: begin
          // row counter back to one, decoder drive untouched
          phase   = SCAN_IDLE;
          row_ptr = kpsd_pkg::ROW_FIRST;
        end
        default: phase = SCAN_IDLE;
      endcase
      r.key_found = key_pulse;
    end
    r.key_code   = held_key;
    r.row_select = row_drive;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Keypad activity generation
  // ---------------------------------------------------------------------
  keypad_event_t     keypad_events[$];     // items waiting to go out
  kpsd_pkg::result_t predicted_reports[$]; // one per accepted transfer
  int                events_queued;

  task automatic push_event(input logic is_tick, input kpsd_pkg::sense_t code);
    keypad_event_t ev;
    ev.is_tick = is_tick;
    ev.code    = code;
    keypad_events.push_back(ev);
    events_queued++;
  endtask

  task automatic push_poll(input kpsd_pkg::sense_t code);
    push_event(FUNC_POLL, code);
  endtask

  // Tick payload is random; the block must ignore it
  task automatic push_ticks(input int n);
    repeat (n) push_event(FUNC_TICK, kpsd_pkg::sense_t'($urandom_range(0, 7)));
  endtask

  function automatic kpsd_pkg::sense_t key_up_code();
    kpsd_pkg::sense_t c;
    c = kpsd_pkg::sense_t'($urandom_range(0, 7));
    c[kpsd_pkg::SENSE_ANY_BIT] = 1'b0;
    return c;
  endfunction

  function automatic kpsd_pkg::sense_t key_down_code();
    kpsd_pkg::sense_t c;
    c = kpsd_pkg::sense_t'($urandom_range(0, 7));
    c[kpsd_pkg::SENSE_ANY_BIT] = 1'b1;
    return c;
  endfunction

  // A full press and release with random content and occasional bounces
  task automatic push_keystroke();
    kpsd_pkg::sense_t down;
    kpsd_pkg::sense_t cap;
    int               early;
    down = key_down_code();
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0) push_ticks(1);
      else push_poll(key_up_code());
    end
    push_poll(down);                                   // idle sees a key
    cap = ($urandom_range(0, 6) == 0) ? kpsd_pkg::sense_t'($urandom_range(0, 7)) : down;
    push_poll(cap);                                    // capture
    // press debounce: maybe an early poll, maybe a bounce
    if (press_wait != 0 && $urandom_range(0, 4) == 0) begin
      early = $urandom_range(0, press_wait - 1);
      push_ticks(early);
      push_poll(cap);
    end
    if ($urandom_range(0, 3) == 0) begin
      push_ticks(press_wait + $urandom_range(0, 2));
      push_poll(cap ^ kpsd_pkg::sense_t'($urandom_range(1, 7)));
    end
    push_ticks(press_wait + $urandom_range(0, 3));
    push_poll(cap);
    push_poll(kpsd_pkg::sense_t'($urandom_range(0, 7)));   // decode
    if ($urandom_range(0, 9) < 6) begin
      push_poll(key_down_code());                          // still held
      if ($urandom_range(0, 3) == 0) begin
        push_ticks(release_wait + $urandom_range(0, 2));
        push_poll(kpsd_pkg::sense_t'($urandom_range(1, 7)));
      end
      push_ticks(release_wait + $urandom_range(0, 3));
      push_poll(kpsd_pkg::SENSE_NONE);
    end else begin
      push_poll(key_up_code());
    end
    push_poll(kpsd_pkg::sense_t'($urandom_range(0, 7)));   // released
  endtask

  task automatic push_random_phase(input int target);
    int start;
    start = events_queued;
    while (events_queued - start < target) begin
      if ($urandom_range(0, 99) < 85) begin
        push_keystroke();
      end else begin
        repeat ($urandom_range(1, 6))
          push_event(logic'($urandom_range(0, 1)), kpsd_pkg::sense_t'($urandom_range(0, 7)));
      end
    end
  endtask

  task automatic push_directed();
    push_ticks(1);
    // idle row cycling up to the wrap, all key-up codes
    push_poll(kpsd_pkg::SENSE_NONE);
    push_poll(SENSE_STRAY_B0);
    push_poll(SENSE_STRAY_B2);
    push_poll(SENSE_STRAY_B20);
    push_poll(kpsd_pkg::SENSE_NONE);
    // unknown column code captured: decodes to no key
    push_poll(kpsd_pkg::SENSE_COL2);
    push_poll(SENSE_STRAY_B20);
    push_poll(SENSE_STRAY_B20);
    push_poll(kpsd_pkg::SENSE_NONE);
    // held, release bounce, then released
    push_poll(kpsd_pkg::SENSE_COL0);
    push_poll(kpsd_pkg::SENSE_COL0);
    push_poll(kpsd_pkg::SENSE_NONE);
    push_poll(kpsd_pkg::SENSE_NONE);
    // press on the first poll after release, press bounce, last column
    push_poll(kpsd_pkg::SENSE_COL3);
    push_poll(kpsd_pkg::SENSE_COL3);
    push_poll(kpsd_pkg::SENSE_COL1);
    push_poll(kpsd_pkg::SENSE_COL3);
    push_poll(kpsd_pkg::SENSE_NONE);
    push_poll(kpsd_pkg::SENSE_NONE);
    push_poll(kpsd_pkg::SENSE_NONE);
    push_ticks(1);
  endtask

  // ---------------------------------------------------------------------
  // Source side: one item per transfer, random gaps
  // ---------------------------------------------------------------------
  logic in_took = 1'b0;   // last offer was taken at the previous rising edge
  int   gap_left;
  int   sender_calm;

  function automatic int pick_gap();
    int r;
    if (sender_calm != 0) begin
      sender_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      sender_calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      gap_left  <= 0;
    end else if (drv_valid && !in_took) begin
      // offer stands until transferred
    end else if (gap_left != 0) begin
      drv_valid <= 1'b0;
      gap_left  <= gap_left - 1;
    end else if (keypad_events.size() != 0) begin
      keypad_event_t ev;
      ev = keypad_events.pop_front();
      drv_valid <= 1'b1;
      drv_func  <= ev.is_tick;
      drv_code  <= ev.code;
      gap_left  <= pick_gap();
    end else begin
      drv_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Sink side: random stalls plus requested long hold-offs
  // ---------------------------------------------------------------------
  int hold_left;
  int receiver_calm;
  int long_holds_wanted;
  int long_holds_served;

  function automatic int pick_stall();
    int r;
    if (receiver_calm != 0) begin
      receiver_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      receiver_calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      sink_ready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (long_holds_served < long_holds_wanted) begin
      // output register fills, then the input channel backs up
      sink_ready        <= 1'b0;
      hold_left         <= LONG_HOLD;
      long_holds_served <= long_holds_served + 1;
    end else begin
      int s;
      s = pick_stall();
      if (s == 0) begin
        sink_ready <= 1'b1;
      end else begin
        sink_ready <= 1'b0;
        hold_left  <= s - 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Transfer tracking and result checking at the rising edge
  // ---------------------------------------------------------------------
  int result_errors;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready)
        predicted_reports.push_back(advance_scanner(in_ch.func, in_ch.sense_code));
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_reports.size() == 0) begin
          result_errors++;
          if (result_errors <= MAX_REPORTS)
            $display("unexpected result transfer: found=%0d key=%02h row=%0d",
                     out_ch.key_found, out_ch.key_code, out_ch.row_select);
        end else begin
          kpsd_pkg::result_t want;
          want = predicted_reports.pop_front();
          if (out_ch.key_found !== want.key_found || out_ch.key_code !== want.key_code ||
              out_ch.row_select !== want.row_select) begin
            result_errors++;
            if (result_errors <= MAX_REPORTS)
              $display({"scan result differs: expected found=%0d key=%02h row=%0d,",
                        " got found=%0d key=%02h row=%0d"},
                       want.key_found, want.key_code, want.row_select,
                       out_ch.key_found, out_ch.key_code, out_ch.row_select);
          end
        end
      end
    end
  end

  // Watchdog
  int cycle_count;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("keypad_scan_debounce: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencing: reset, then settle settings phase by phase
  // ---------------------------------------------------------------------

  // Block is idle once nothing is queued, offered or owed
  task automatic wait_drained();
    while (keypad_events.size() != 0 || drv_valid || predicted_reports.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_setting(input kpsd_pkg::cfg_index_t idx,
                               input kpsd_pkg::settle_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == kpsd_pkg::CFG_PRESS_SETTLE) press_wait = val;
    else release_wait = val;
  endtask

  task automatic run_phase(input kpsd_pkg::settle_t press, input kpsd_pkg::settle_t rel_ticks,
                           input int items);
    wait_drained();
    write_setting(kpsd_pkg::CFG_PRESS_SETTLE, press);
    write_setting(kpsd_pkg::CFG_RELEASE_SETTLE, rel_ticks);
    push_random_phase(items);
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = kpsd_pkg::CFG_PRESS_SETTLE;
    cfg_wdata         = '0;
    gap_left          = 0;
    hold_left         = 0;
    sender_calm       = 0;
    receiver_calm     = 0;
    long_holds_wanted = 0;
    long_holds_served = 0;
    result_errors     = 0;
    cycle_count       = 0;
    events_queued     = 0;
    reset_scanner();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settle times as they come out of reset
    push_random_phase(100);

    // zero settle: every poll compares at once
    wait_drained();
    write_setting(kpsd_pkg::CFG_PRESS_SETTLE, '0);
    write_setting(kpsd_pkg::CFG_RELEASE_SETTLE, '0);
    push_directed();
    push_random_phase(120);

    run_phase(kpsd_pkg::SETTLE_MAX, kpsd_pkg::SETTLE_MAX, 200);

    // short settles with a long sink hold-off while items keep coming
    run_phase(6'd1, 6'd2, 120);
    long_holds_wanted = long_holds_wanted + 1;

    run_phase('0, kpsd_pkg::SETTLE_MAX, 120);
    run_phase(kpsd_pkg::SETTLE_MAX, '0, 150);
    run_phase(kpsd_pkg::settle_t'($urandom_range(0, 12)),
              kpsd_pkg::settle_t'($urandom_range(0, 12)), 120);
    long_holds_wanted = long_holds_wanted + 1;
    run_phase(kpsd_pkg::PRESS_SETTLE_RST, kpsd_pkg::RELEASE_SETTLE_RST, 80);

    wait_drained();
    repeat (4) @(posedge clk);
    if (result_errors == 0 && predicted_reports.size() == 0) begin
      $display("keypad_scan_debounce: match");
    end else begin
      $display("keypad_scan_debounce: mismatch");
    end
    $finish;
  end

endmodule
